### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ALU checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge outside reset
`define SABD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sabd: assertion failed");

// check that sig is stable in the cycle after cond
`define SABD_ASSERT_HOLD(name, clk, rstn, cond, sig) \
  `SABD_ASSERT(name, clk, rstn, (cond) |=> $stable(sig))

`endif

### rtl/sabd_pkg.sv
// ----------------------------------------------------------------------------
// sabd_pkg
// Types and constants shared by the signed ALU core, its cells and checker.
// ----------------------------------------------------------------------------
package sabd_pkg;

  localparam int unsigned DATA_WIDTH = 8;
  localparam int unsigned CMD_WIDTH  = 2;
  localparam int unsigned OPD_WIDTH  = 8;
  localparam int unsigned RES_WIDTH  = 16;
  localparam int unsigned REM_WIDTH  = 8;
  localparam int unsigned ST_WIDTH   = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  typedef enum logic [ST_WIDTH-1:0] {
    ST_OK   = 2'b00,
    ST_OVF  = 2'b01,
    ST_DIV0 = 2'b10
  } status_e;

  typedef struct packed {
    cmd_e                        command;
    logic signed [OPD_WIDTH-1:0] operand_a;
    logic signed [OPD_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] result_value;
    logic signed [REM_WIDTH-1:0] remainder_value;
    logic [ST_WIDTH-1:0]         status;
  } rsp_t;

  typedef struct packed {
    cmd_e cmd;
    logic a_neg;
    logic b_neg;
    logic ovf;
    logic div0;
  } ctrl_t;

endpackage

### rtl/sabd_cell.sv
// ----------------------------------------------------------------------------
// sabd_cell
// One step of the chain: a Booth radix-2 step for multiply or a restoring
// division step for divide, registered toward the next cell.
// ----------------------------------------------------------------------------
module sabd_cell #(
  parameter int unsigned W = sabd_pkg::DATA_WIDTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  sabd_pkg::ctrl_t ctrl_i,
  input  logic [W:0]    acc_i,
  input  logic [W-1:0]  low_i,
  input  logic          qm1_i,
  input  logic [W-1:0]  m_i,
  output logic          valid_o,
  output sabd_pkg::ctrl_t ctrl_o,
  output logic [W:0]    acc_o,
  output logic [W-1:0]  low_o,
  output logic          qm1_o,
  output logic [W-1:0]  m_o
);

  logic         valid_q;
  logic [W:0]   acc_d, acc_q;
  logic [W-1:0] low_d, low_q;
  logic         qm1_d, qm1_q;
  logic [W:0]   m_ext;
  logic [W:0]   booth_sum;
  logic [W:0]   trial;
  logic [W:0]   diff;

  assign m_ext = {m_i[W-1], m_i};
  assign trial = {acc_i[W-1:0], low_i[W-1]};
  assign diff  = trial - {1'b0, m_i};

  always_comb begin
    case ({low_i[0], qm1_i})
      2'b01:   booth_sum = acc_i + m_ext;
      2'b10:   booth_sum = acc_i - m_ext;
      default: booth_sum = acc_i;
    endcase
  end

  always_comb begin
    acc_d = acc_i;
    low_d = low_i;
    qm1_d = qm1_i;
    case (ctrl_i.cmd)
      sabd_pkg::CMD_MUL: begin
        acc_d = {booth_sum[W], booth_sum[W:1]};
        low_d = {booth_sum[0], low_i[W-1:1]};
        qm1_d = low_i[0];
      end
      sabd_pkg::CMD_DIV: begin
        if (!diff[W]) begin
          acc_d = diff;
          low_d = {low_i[W-2:0], 1'b1};
        end else begin
          acc_d = trial;
          low_d = {low_i[W-2:0], 1'b0};
        end
      end
      default: begin
        acc_d = acc_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctrl_o <= ctrl_i;
      acc_q  <= acc_d;
      low_q  <= low_d;
      qm1_q  <= qm1_d;
      m_o    <= m_i;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign low_o   = low_q;
  assign qm1_o   = qm1_q;

endmodule

### rtl/sabd_finish.sv
// ----------------------------------------------------------------------------
// sabd_finish
// Turns the state left by the last cell into a response: product assembly,
// quotient and remainder sign fix, and field extension.
// ----------------------------------------------------------------------------
module sabd_finish #(
  parameter int unsigned W = sabd_pkg::DATA_WIDTH
) (
  input  sabd_pkg::ctrl_t ctrl_i,
  input  logic [W:0]      acc_i,
  input  logic [W-1:0]    low_i,
  output sabd_pkg::rsp_t  rsp_o
);

  localparam int unsigned PW = (2 * W > sabd_pkg::RES_WIDTH) ? 2 * W : sabd_pkg::RES_WIDTH;
  localparam int unsigned XW = (W > sabd_pkg::RES_WIDTH) ? W : sabd_pkg::RES_WIDTH;
  localparam int unsigned RW = (W > sabd_pkg::REM_WIDTH) ? W : sabd_pkg::REM_WIDTH;

  logic [2*W-1:0] prod;
  logic [PW-1:0]  prod_x;
  logic [W-1:0]   quo;
  logic [W-1:0]   rem;
  logic [W-1:0]   word;
  logic [XW-1:0]  word_x;
  logic [RW-1:0]  rem_x;

  assign prod   = {acc_i[W-1:0], low_i};
  assign prod_x = PW'(signed'(prod));
  assign quo    = (ctrl_i.a_neg ^ ctrl_i.b_neg) ? -low_i : low_i;
  assign rem    = ctrl_i.a_neg ? -acc_i[W-1:0] : acc_i[W-1:0];
  assign word   = (ctrl_i.cmd == sabd_pkg::CMD_DIV) ? quo : low_i;
  assign word_x = XW'(signed'(word));
  assign rem_x  = RW'(signed'(rem));

  always_comb begin
    rsp_o.result_value    = word_x[sabd_pkg::RES_WIDTH-1:0];
    rsp_o.remainder_value = '0;
    rsp_o.status          = sabd_pkg::ST_OK;
    case (ctrl_i.cmd)
      sabd_pkg::CMD_ADD, sabd_pkg::CMD_SUB: begin
        if (ctrl_i.ovf) begin
          rsp_o.status = sabd_pkg::ST_OVF;
        end
      end
      sabd_pkg::CMD_MUL: begin
        rsp_o.result_value = prod_x[sabd_pkg::RES_WIDTH-1:0];
      end
      sabd_pkg::CMD_DIV: begin
        if (ctrl_i.div0) begin
          rsp_o.result_value = '0;
          rsp_o.status       = sabd_pkg::ST_DIV0;
        end else begin
          rsp_o.remainder_value = rem_x[sabd_pkg::REM_WIDTH-1:0];
        end
      end
      default: begin
        rsp_o.status = sabd_pkg::ST_OK;
      end
    endcase
  end

endmodule

### rtl/sabd_out_buf.sv
// ----------------------------------------------------------------------------
// sabd_out_buf
// Output register with one spare entry, so the chain's advance depends only
// on registered state.
// ----------------------------------------------------------------------------
module sabd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sabd_pkg::rsp_t rsp_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sabd_pkg::rsp_t out_rsp_o
);

  logic           out_valid_d, out_valid_q;
  logic           spare_valid_d, spare_valid_q;
  logic           ready_q;
  sabd_pkg::rsp_t out_rsp_d, out_rsp_q;
  sabd_pkg::rsp_t spare_d, spare_q;

  always_comb begin
    out_valid_d   = out_valid_q;
    spare_valid_d = spare_valid_q;
    out_rsp_d     = out_rsp_q;
    spare_d       = spare_q;
    if (!out_valid_q || out_ready_i) begin
      if (spare_valid_q) begin
        out_valid_d   = 1'b1;
        out_rsp_d     = spare_q;
        spare_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_rsp_d   = rsp_i;
      end
    end else if (push_i) begin
      spare_valid_d = 1'b1;
      spare_d       = rsp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      spare_valid_q <= 1'b0;
      ready_q       <= 1'b1;
    end else begin
      out_valid_q   <= out_valid_d;
      spare_valid_q <= spare_valid_d;
      ready_q       <= !spare_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    spare_q   <= spare_d;
  end

  assign ready_o     = ready_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### rtl/signed_alu_add_sub_booth_mul_div_core.sv
// ----------------------------------------------------------------------------
// signed_alu_add_sub_booth_mul_div_core
// Signed ALU: add, subtract, Booth radix-2 multiply, truncating divide.
// ----------------------------------------------------------------------------
// A new request is taken every cycle while the output side is not stalled,
// and each yields one response after passing through one operand stage, a
// chain of DATA_WIDTH cells each doing one Booth or one restoring division
// step, and the output register. Add and subtract are computed in the
// operand stage and ride the chain unchanged, so every command has the
// same latency and responses leave in request order.
module signed_alu_add_sub_booth_mul_div_core #(
  parameter int unsigned DATA_WIDTH = sabd_pkg::DATA_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sabd_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sabd_pkg::rsp_t out_rsp_o
);

  localparam int unsigned W = DATA_WIDTH;

  logic                  adv;
  logic [sabd_pkg::OPD_WIDTH-1:0] a_raw;
  logic [sabd_pkg::OPD_WIDTH-1:0] b_raw;
  logic [W-1:0]          a_w;
  logic [W-1:0]          b_w;
  logic [W-1:0]          b_eff;
  logic                  sub;
  logic [W-1:0]          sum;
  logic                  ovf;
  logic [W-1:0]          a_mag;
  logic [W-1:0]          b_mag;

  sabd_pkg::ctrl_t       ctrl_d;
  logic [W-1:0]          low_d;
  logic [W-1:0]          m_d;

  logic                  valid_c [W+1];
  sabd_pkg::ctrl_t       ctrl_c  [W+1];
  logic [W:0]            acc_c   [W+1];
  logic [W-1:0]          low_c   [W+1];
  logic                  qm1_c   [W+1];
  logic [W-1:0]          m_c     [W+1];

  logic                  valid0_q;
  sabd_pkg::ctrl_t       ctrl0_q;
  logic [W-1:0]          low0_q;
  logic [W-1:0]          m0_q;

  sabd_pkg::rsp_t        fin_rsp;

  assign a_raw = in_req_i.operand_a;
  assign b_raw = in_req_i.operand_b;
  assign a_w   = W'(a_raw);
  assign b_w   = W'(b_raw);

  assign sub   = (in_req_i.command == sabd_pkg::CMD_SUB);
  assign b_eff = sub ? ~b_w : b_w;
  assign sum   = a_w + b_eff + W'(sub);
  assign ovf   = (a_w[W-1] == b_eff[W-1]) && (sum[W-1] != a_w[W-1]);
  assign a_mag = a_w[W-1] ? -a_w : a_w;
  assign b_mag = b_w[W-1] ? -b_w : b_w;

  always_comb begin
    ctrl_d.cmd   = in_req_i.command;
    ctrl_d.a_neg = a_w[W-1];
    ctrl_d.b_neg = b_w[W-1];
    ctrl_d.ovf   = ovf;
    ctrl_d.div0  = (b_w == '0);
    low_d        = sum;
    m_d          = '0;
    case (in_req_i.command)
      sabd_pkg::CMD_MUL: begin
        low_d = a_w;
        m_d   = b_w;
      end
      sabd_pkg::CMD_DIV: begin
        low_d = a_mag;
        m_d   = b_mag;
      end
      default: begin
        low_d = sum;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (adv) begin
      valid0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl0_q <= ctrl_d;
      low0_q  <= low_d;
      m0_q    <= m_d;
    end
  end

  assign valid_c[0] = valid0_q;
  assign ctrl_c[0]  = ctrl0_q;
  assign acc_c[0]   = '0;
  assign low_c[0]   = low0_q;
  assign qm1_c[0]   = 1'b0;
  assign m_c[0]     = m0_q;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sabd_cell #(
      .W (W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_c[i]),
      .ctrl_i  (ctrl_c[i]),
      .acc_i   (acc_c[i]),
      .low_i   (low_c[i]),
      .qm1_i   (qm1_c[i]),
      .m_i     (m_c[i]),
      .valid_o (valid_c[i+1]),
      .ctrl_o  (ctrl_c[i+1]),
      .acc_o   (acc_c[i+1]),
      .low_o   (low_c[i+1]),
      .qm1_o   (qm1_c[i+1]),
      .m_o     (m_c[i+1])
    );
  end

  sabd_finish #(
    .W (W)
  ) u_finish (
    .ctrl_i (ctrl_c[W]),
    .acc_i  (acc_c[W]),
    .low_i  (low_c[W]),
    .rsp_o  (fin_rsp)
  );

  sabd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (valid_c[W] && adv),
    .rsp_i       (fin_rsp),
    .ready_o     (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  assign in_ready_o = adv;

endmodule

### rtl/sabd_checker.sv
// ----------------------------------------------------------------------------
// sabd_checker
// Port-level checks on the signed ALU core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sabd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input sabd_pkg::rsp_t out_rsp_o
);

  logic out_stall;
  logic div0_rsp;
  logic ovf_rsp;
  logic rem_set;
  logic rsp_zero;
  logic rem_zero;
  logic st_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign div0_rsp  = out_valid_o && (out_rsp_o.status == sabd_pkg::ST_DIV0);
  assign ovf_rsp   = out_valid_o && (out_rsp_o.status == sabd_pkg::ST_OVF);
  assign rem_set   = out_valid_o && (out_rsp_o.remainder_value != '0);
  assign rem_zero  = (out_rsp_o.remainder_value == '0);
  assign rsp_zero  = (out_rsp_o.result_value == '0) && rem_zero;
  assign st_ok     = (out_rsp_o.status == sabd_pkg::ST_OK);

  `SABD_ASSERT_HOLD(a_out_valid_hold, clk_i, rst_ni, out_stall, out_valid_o)
  `SABD_ASSERT_HOLD(a_out_rsp_hold, clk_i, rst_ni, out_stall, out_rsp_o)
  `SABD_ASSERT(a_div0_zero, clk_i, rst_ni, div0_rsp |-> rsp_zero)
  `SABD_ASSERT(a_ovf_no_rem, clk_i, rst_ni, ovf_rsp |-> rem_zero)
  `SABD_ASSERT(a_rem_ok, clk_i, rst_ni, rem_set |-> st_ok)

endmodule

bind signed_alu_add_sub_booth_mul_div_core sabd_checker u_sabd_checker (.*);
